### hw/rtl/tcw_pkg.sv
// tcw_pkg: constants, codes, types and the cell address helper of the text console writer
// used by every file of the block; depends on nothing

package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_WIDTH  = 8;
  localparam int CELL_COUNT = ROWS * COLUMNS;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CNT_W  = $clog2(CELL_COUNT + 1);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);

  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;
  localparam int POS_W  = 11;
  localparam int ATTR_W = 8;
  localparam int WORD_W = 16;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LINEFEED  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_FILL,
    ST_CLEAR,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } ram_req_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             wr;
    logic             scroll;
  } cur_upd_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    cell_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col));
  endfunction

endpackage

### hw/rtl/tcw_cell_ram.sv
// tcw_cell_ram: screen cell store, one write port and one registered read port
// depends on tcw_pkg for depth, widths and the request struct

module tcw_cell_ram (
  input  logic                            clk,
  input  tcw_pkg::ram_req_t               req,
  output logic [tcw_pkg::WORD_W-1:0]      rd_data
);

  logic [tcw_pkg::WORD_W-1:0] mem [tcw_pkg::CELL_COUNT];
  logic [tcw_pkg::WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/tcw_cursor.sv
// tcw_cursor: next cursor column and row for one put, with wrap and scroll detect
// depends on tcw_pkg for geometry, character codes and the update struct

module tcw_cursor (
  input  logic [tcw_pkg::COL_W-1:0]  cur_col,
  input  logic [tcw_pkg::ROW_W-1:0]  cur_row,
  input  logic [tcw_pkg::CHAR_W-1:0] char_byte,
  output tcw_pkg::cur_upd_t          upd
);

  localparam int CX_W = tcw_pkg::COL_W + 1;
  localparam int RX_W = tcw_pkg::ROW_W + 1;

  logic [CX_W-1:0] cx;
  logic [RX_W-1:0] rx;
  logic [CX_W-1:0] tab_col;
  logic            wr;

  assign tab_col = CX_W'(((int'(cur_col) / tcw_pkg::TAB_WIDTH) + 1) * tcw_pkg::TAB_WIDTH);

  always_comb begin
    cx = {1'b0, cur_col};
    rx = {1'b0, cur_row};
    wr = 1'b0;
    priority if (char_byte == tcw_pkg::CH_BACKSPACE && cur_col != '0) begin
      cx = cx - CX_W'(1);
    end else if (char_byte == tcw_pkg::CH_TAB) begin
      cx = tab_col;
    end else if (char_byte == tcw_pkg::CH_RETURN) begin
      cx = '0;
    end else if (char_byte == tcw_pkg::CH_LINEFEED) begin
      cx = '0;
      rx = rx + RX_W'(1);
    end else if (!char_byte[tcw_pkg::CHAR_W-1] && char_byte >= tcw_pkg::CH_SPACE) begin
      wr = 1'b1;
      cx = cx + CX_W'(1);
    end else begin
      wr = 1'b0;
    end
    // wrap past the last column
    if (cx >= CX_W'(tcw_pkg::COLUMNS)) begin
      cx = '0;
      rx = rx + RX_W'(1);
    end
    upd.scroll = (rx >= RX_W'(tcw_pkg::ROWS));
    upd.row    = upd.scroll ? tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1) : rx[tcw_pkg::ROW_W-1:0];
    upd.col    = cx[tcw_pkg::COL_W-1:0];
    upd.wr     = wr;
  end

endmodule

### hw/rtl/text_console_writer_core.sv
// text_console_writer_core: text console top level, sequencer, cursor and output register
// depends on tcw_pkg, tcw_cursor and tcw_cell_ram

// Text console over an 80 by 25 store of 16-bit cells (attribute high, character low).
// Input channel (in_valid/in_stall) carries one word per operation: put character,
// clear screen or read cell. Each accepted word gives one result word on the output
// channel (out_valid/out_stall): cursor position after the operation and, for a read,
// the cell contents (zero otherwise).
// in_stall is high from the cycle after an accept until the result is loaded into
// the output register; the next word may be accepted while that result still waits.
// A put without scroll, an unused operation and an out-of-range read go straight to the
// done step; a read first passes through a read step (registered memory read); a clear
// writes one cell per cycle; and a put that scrolls runs the copy, which walks one cell
// per cycle through the single write port, then the last row fills.
// A stalled receiver holds the result; a finished item waits in its last step until
// the output register frees up.
// cfg_color_attribute is written when cfg_valid is high (cfg_ready is always high);
// write it only while the block is idle.
// Reset (rst_n low, synchronous) homes the cursor and sets the attribute to 7; the
// cell store is not cleared, so software issues a clear first.

module text_console_writer_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tcw_pkg::OP_W-1:0]      in_operation,
  input  logic [tcw_pkg::CHAR_W-1:0]    in_char_byte,
  input  logic [tcw_pkg::IDX_W-1:0]     in_cell_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tcw_pkg::POS_W-1:0]     out_cursor_position,
  output logic [tcw_pkg::WORD_W-1:0]    out_cell_word,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tcw_pkg::ATTR_W-1:0]    cfg_color_attribute
);

  localparam int CNT_W  = tcw_pkg::CNT_W;
  localparam int ADDR_W = tcw_pkg::ADDR_W;

  tcw_pkg::state_t state_r, state_nxt;

  logic                          out_valid_r;
  logic [tcw_pkg::POS_W-1:0]     out_pos_r;
  logic [tcw_pkg::WORD_W-1:0]    out_word_r;
  logic [tcw_pkg::COL_W-1:0]     col_r, col_nxt;
  logic [tcw_pkg::ROW_W-1:0]     row_r, row_nxt;
  logic [tcw_pkg::ATTR_W-1:0]    attr_r;
  logic [CNT_W-1:0]              ctr_r, ctr_nxt;
  logic [tcw_pkg::WORD_W-1:0]    word_r, word_nxt;

  logic                          in_acc;
  logic                          out_ld;
  logic                          rd_in_range;
  logic [tcw_pkg::WORD_W-1:0]    blank;
  logic [tcw_pkg::WORD_W-1:0]    rd_data;
  tcw_pkg::ram_req_t             req;
  tcw_pkg::cur_upd_t             upd;

  assign in_stall    = (state_r != tcw_pkg::ST_IDLE);
  assign in_acc      = in_valid && !in_stall;
  assign out_ld      = (state_r == tcw_pkg::ST_DONE) && (!out_valid_r || !out_stall);
  assign rd_in_range = (32'(in_cell_index) < tcw_pkg::CELL_COUNT);
  assign blank       = {attr_r, tcw_pkg::CH_SPACE};
  assign cfg_ready   = 1'b1;

  tcw_cursor u_cursor (
    .cur_col   (col_r),
    .cur_row   (row_r),
    .char_byte (in_char_byte),
    .upd       (upd)
  );

  tcw_cell_ram u_ram (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcw_pkg::ST_IDLE: begin
        if (in_acc) begin
          priority if (in_operation == tcw_pkg::OP_PUT) begin
            state_nxt = upd.scroll ? tcw_pkg::ST_COPY : tcw_pkg::ST_DONE;
          end else if (in_operation == tcw_pkg::OP_CLEAR) begin
            state_nxt = tcw_pkg::ST_CLEAR;
          end else if (in_operation == tcw_pkg::OP_READ && rd_in_range) begin
            state_nxt = tcw_pkg::ST_READ;
          end else begin
            state_nxt = tcw_pkg::ST_DONE;
          end
        end
      end
      tcw_pkg::ST_COPY: begin
        if (ctr_r == CNT_W'(tcw_pkg::CELL_COUNT)) begin
          state_nxt = tcw_pkg::ST_FILL;
        end
      end
      tcw_pkg::ST_FILL, tcw_pkg::ST_CLEAR: begin
        if (ctr_r == CNT_W'(tcw_pkg::CELL_COUNT - 1)) begin
          state_nxt = tcw_pkg::ST_DONE;
        end
      end
      tcw_pkg::ST_READ: begin
        state_nxt = tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_DONE: begin
        if (out_ld) begin
          state_nxt = tcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  // memory requests, counter, cursor and read word
  always_comb begin
    req      = '0;
    ctr_nxt  = ctr_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    word_nxt = word_r;
    unique case (state_r)
      tcw_pkg::ST_IDLE: begin
        if (in_acc) begin
          word_nxt = '0;
          priority if (in_operation == tcw_pkg::OP_PUT) begin
            req.wr_en   = upd.wr;
            req.wr_addr = tcw_pkg::cell_addr(row_r, col_r);
            req.wr_data = {attr_r, in_char_byte};
            col_nxt     = upd.col;
            row_nxt     = upd.row;
            ctr_nxt     = CNT_W'(tcw_pkg::COLUMNS);
          end else if (in_operation == tcw_pkg::OP_CLEAR) begin
            col_nxt = '0;
            row_nxt = '0;
            ctr_nxt = '0;
          end else if (in_operation == tcw_pkg::OP_READ) begin
            req.rd_en   = rd_in_range;
            req.rd_addr = ADDR_W'(in_cell_index);
          end else begin
            word_nxt = '0;
          end
        end
      end
      tcw_pkg::ST_COPY: begin
        // read one row ahead, write the word read last cycle one row up
        req.rd_en   = (ctr_r < CNT_W'(tcw_pkg::CELL_COUNT));
        req.rd_addr = ctr_r[ADDR_W-1:0];
        req.wr_en   = (ctr_r != CNT_W'(tcw_pkg::COLUMNS));
        req.wr_addr = ADDR_W'(ctr_r - CNT_W'(tcw_pkg::COLUMNS) - CNT_W'(1));
        req.wr_data = rd_data;
        if (ctr_r == CNT_W'(tcw_pkg::CELL_COUNT)) begin
          ctr_nxt = CNT_W'((tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS);
        end else begin
          ctr_nxt = ctr_r + CNT_W'(1);
        end
      end
      tcw_pkg::ST_FILL, tcw_pkg::ST_CLEAR: begin
        req.wr_en   = 1'b1;
        req.wr_addr = ctr_r[ADDR_W-1:0];
        req.wr_data = blank;
        ctr_nxt     = ctr_r + CNT_W'(1);
      end
      tcw_pkg::ST_READ: begin
        word_nxt = rd_data;
      end
      tcw_pkg::ST_DONE: begin
        word_nxt = word_r;
      end
      default: begin
        word_nxt = word_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcw_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      attr_r      <= tcw_pkg::ATTR_RESET;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      if (cfg_valid && cfg_ready) begin
        attr_r <= cfg_color_attribute;
      end
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ctr_r  <= ctr_nxt;
    word_r <= word_nxt;
    if (out_ld) begin
      out_pos_r  <= tcw_pkg::POS_W'(tcw_pkg::cell_addr(row_r, col_r));
      out_word_r <= word_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cursor_position = out_pos_r;
  assign out_cell_word       = out_word_r;

endmodule

### hw/rtl/tcw_checker.sv
// tcw_checker: port-level assertions for the text console writer, bound to the top level
// depends on tcw_pkg and text_console_writer_core

module tcw_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [tcw_pkg::POS_W-1:0]     out_cursor_position,
  input logic [tcw_pkg::WORD_W-1:0]    out_cell_word
);

  // every accepted word puts the block into a busy period, input stalled
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accept");

  // a result only appears at the end of a busy period
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without preceding work");

  // cursor stays on the screen
  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_cursor_position) < tcw_pkg::CELL_COUNT))
    else $error("cursor position off screen");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_cursor_position) && $stable(out_cell_word)))
    else $error("stalled result word changed");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (.*);

### test/text_console_writer_core_test.sv
// text_console_writer_core_test: self-checking testbench of the text console writer core
// sends put, clear, read and unused words with random idling; checks every result word
// depends on tcw_pkg and text_console_writer_core

module text_console_writer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam logic [OP_W-1:0]   OP_UNUSED     = 2'd3;
  localparam logic [CHAR_W-1:0] PRINTABLE_TOP = 8'h7F;
  localparam logic [IDX_W-1:0]  IDX_TOP       = '1;
  localparam int                TAIL_CYCLES   = CELL_COUNT + 16;

  typedef struct {
    logic [POS_W-1:0]  cursor_position;
    logic [WORD_W-1:0] cell_word;
  } console_result_t;

  logic               clk                 = 1'b0;
  logic               rst_n               = 1'b0;
  logic               in_valid            = 1'b0;
  logic               in_stall;
  logic [OP_W-1:0]    in_operation        = OP_PUT;
  logic [CHAR_W-1:0]  in_char_byte        = '0;
  logic [IDX_W-1:0]   in_cell_index       = '0;
  logic               out_valid;
  logic               out_stall           = 1'b0;
  logic [POS_W-1:0]   out_cursor_position;
  logic [WORD_W-1:0]  out_cell_word;
  logic               cfg_valid           = 1'b0;
  logic               cfg_ready;
  logic [ATTR_W-1:0]  cfg_color_attribute = '0;

  // screen and cursor as the block should hold them after every accepted word
  console_result_t    expected_results[$];
  logic [WORD_W-1:0]  screen_model[CELL_COUNT];
  int unsigned        model_col;
  int unsigned        model_row;
  logic [ATTR_W-1:0]  model_attr = ATTR_RESET;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  int failures;

  text_console_writer_core uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_char_byte        (in_char_byte),
    .in_cell_index       (in_cell_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_cursor_position (out_cursor_position),
    .out_cell_word       (out_cell_word),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_color_attribute (cfg_color_attribute)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [CHAR_W-1:0] rand_char();
    return CHAR_W'($urandom_range(255));
  endfunction

  function automatic logic [CHAR_W-1:0] rand_printable();
    return CHAR_W'($urandom_range(PRINTABLE_TOP, CH_SPACE));
  endfunction

  function automatic logic [IDX_W-1:0] rand_index();
    return IDX_W'($urandom_range(IDX_TOP));
  endfunction

  function automatic void predict_console(input logic [OP_W-1:0] op,
                                          input logic [CHAR_W-1:0] ch,
                                          input logic [IDX_W-1:0] idx);
    console_result_t res;
    logic [WORD_W-1:0] blank;
    blank         = {model_attr, CH_SPACE};
    res.cell_word = '0;
    case (op)
      OP_PUT: begin
        if (ch == CH_BACKSPACE && model_col != 0)
          model_col--;
        else if (ch == CH_TAB)
          model_col = (model_col / TAB_WIDTH + 1) * TAB_WIDTH;
        else if (ch == CH_RETURN)
          model_col = 0;
        else if (ch == CH_LINEFEED) begin
          model_col = 0;
          model_row++;
        end else if (ch >= CH_SPACE && ch <= PRINTABLE_TOP) begin
          screen_model[model_row * COLUMNS + model_col] = {model_attr, ch};
          model_col++;
        end
        if (model_col >= COLUMNS) begin
          model_col = 0;
          model_row++;
        end
        // past the last row: shift up one row, blank the bottom one
        if (model_row >= ROWS) begin
          for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
            screen_model[i] = screen_model[i + COLUMNS];
          for (int i = (ROWS - 1) * COLUMNS; i < CELL_COUNT; i++)
            screen_model[i] = blank;
          model_row = ROWS - 1;
        end
      end
      OP_CLEAR: begin
        foreach (screen_model[i])
          screen_model[i] = blank;
        model_col = 0;
        model_row = 0;
      end
      OP_READ: begin
        if (idx < CELL_COUNT)
          res.cell_word = screen_model[idx];
      end
      default: ;
    endcase
    res.cursor_position = POS_W'(model_row * COLUMNS + model_col);
    expected_results.push_back(res);
  endfunction

  // valid stays high between back-to-back words and drops only for a gap
  task automatic send_word(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                           input logic [IDX_W-1:0] idx);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_char_byte  <= ch;
    in_cell_index <= idx;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_console(op, ch, idx);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    wait_results_drained();
    cfg_valid           <= 1'b1;
    cfg_color_attribute <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid  <= 1'b0;
    model_attr = value;
  endtask

  // text-like traffic: mostly printable puts, some control bytes, reads, rare clears and unused words
  task automatic run_text(input int count, input int lf_pct);
    int                pick;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
    repeat (count) begin
      pick = $urandom_range(99);
      ch   = rand_char();
      idx  = rand_index();
      if (pick < 1)
        send_word(OP_CLEAR, ch, idx);
      else if (pick < 9) begin
        // half the reads look at the cell just before the cursor
        if (pick < 5 && model_row * COLUMNS + model_col != 0)
          idx = IDX_W'(model_row * COLUMNS + model_col - 1);
        send_word(OP_READ, ch, idx);
      end else if (pick < 10)
        send_word(OP_UNUSED, ch, idx);
      else if (pick < 14)
        send_word(OP_PUT, ch, idx);
      else begin
        pick = $urandom_range(99);
        if (pick < lf_pct)
          ch = CH_LINEFEED;
        else if (pick < lf_pct + 4)
          ch = CH_TAB;
        else if (pick < lf_pct + 6)
          ch = CH_BACKSPACE;
        else if (pick < lf_pct + 8)
          ch = CH_RETURN;
        else
          ch = rand_printable();
        send_word(OP_PUT, ch, idx);
      end
    end
  endtask

  task automatic test_control_codes();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_word(OP_CLEAR, 8'h00, '0);
    send_word(OP_READ, 8'h00, '0);
    send_word(OP_PUT, CH_SPACE, '0);
    send_word(OP_PUT, PRINTABLE_TOP, IDX_TOP);
    send_word(OP_PUT, "A", '0);
    send_word(OP_READ, 8'hFF, 11'd2);
    send_word(OP_PUT, CH_BACKSPACE, '0);
    send_word(OP_PUT, CH_RETURN, '0);
    // backspace at column zero does nothing
    send_word(OP_PUT, CH_BACKSPACE, '0);
    send_word(OP_PUT, CH_TAB, '0);
    send_word(OP_PUT, CH_TAB, '0);
    send_word(OP_PUT, 8'h00, '0);
    send_word(OP_PUT, 8'h1F, '0);
    send_word(OP_PUT, 8'h80, '0);
    send_word(OP_PUT, 8'hFF, IDX_TOP);
    send_word(OP_PUT, CH_LINEFEED, '0);
    send_word(OP_PUT, 8'h7E, '0);
    send_word(OP_READ, 8'h00, 11'(COLUMNS));
    send_word(OP_READ, 8'h00, 11'(CELL_COUNT - 1));
    // out of range reads give zero
    send_word(OP_READ, 8'h00, 11'(CELL_COUNT));
    send_word(OP_READ, 8'h00, IDX_TOP);
    send_word(OP_UNUSED, 8'hFF, IDX_TOP);
    send_word(OP_UNUSED, 8'h00, '0);
  endtask

  task automatic test_wrap_and_scroll();
    send_word(OP_CLEAR, rand_char(), rand_index());
    repeat (ROWS + 2) begin
      repeat ($urandom_range(6))
        send_word(OP_PUT, rand_printable(), rand_index());
      send_word(OP_PUT, CH_LINEFEED, rand_index());
    end
    // a long line on the bottom row wraps and scrolls twice
    repeat (2 * COLUMNS + 10)
      send_word(OP_PUT, rand_printable(), rand_index());
    repeat (COLUMNS / TAB_WIDTH + 1)
      send_word(OP_PUT, CH_TAB, rand_index());
    for (int col = 0; col < COLUMNS; col += 9) begin
      send_word(OP_READ, rand_char(), 11'((ROWS - 1) * COLUMNS + col));
      send_word(OP_READ, rand_char(), 11'((ROWS - 2) * COLUMNS + col));
    end
  endtask

  task automatic test_attribute_extremes();
    logic [ATTR_W-1:0] attrs[3];
    attrs = '{8'h00, 8'hFF, ATTR_W'($urandom)};
    foreach (attrs[i]) begin
      write_attribute(attrs[i]);
      send_word(OP_CLEAR, rand_char(), rand_index());
      run_text(150, 8);
    end
  endtask

  task automatic test_idling();
    int send_pcts[4];
    int recv_pcts[4];
    send_pcts = '{0, 76, 0, 8};
    recv_pcts = '{0, 0, 76, 8};
    foreach (send_pcts[i]) begin
      write_attribute(ATTR_W'($urandom));
      send_idle_pct  = send_pcts[i];
      recv_stall_pct = recv_pcts[i];
      run_text(170, 3 + 4 * i);
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // receiver holds off long enough for the block to fill and stall its input
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 400;
    repeat (16)
      send_word(OP_PUT, rand_printable(), rand_index());
    send_word(OP_READ, 8'h00, 11'(model_row * COLUMNS + model_col - 1));
    wait_results_drained();
  endtask

  always @(posedge clk) begin
    console_result_t oldest;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_results.size() == 0) begin
        $error("result word with none expected: cursor_position %0d cell_word %h",
               out_cursor_position, out_cell_word);
        failures++;
      end else begin
        oldest = expected_results.pop_front();
        if (out_cursor_position !== oldest.cursor_position) begin
          $error("cursor_position: expected %0d, got %0d",
                 oldest.cursor_position, out_cursor_position);
          failures++;
        end
        if (out_cell_word !== oldest.cell_word) begin
          $error("cell_word: expected %h, got %h", oldest.cell_word, out_cell_word);
          failures++;
        end
      end
    end
  end

  // receiver stall: a counted hold when asked for, random otherwise
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall   <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_control_codes();
    test_wrap_and_scroll();
    test_attribute_extremes();
    test_idling();
    test_backpressure();
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0 && expected_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
